// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/phdlc_pkg.sv =====
// ---------------------------------------------------------------------------
// PPP async HDLC deframer package
// Result codes, register map, reset values and shared structs.
// ---------------------------------------------------------------------------
package phdlc_pkg;

   localparam int ByteW   = 8;
   localparam int LenW    = 16;
   localparam int KindW   = 2;
   localparam int CntW    = 2;
   localparam int HeldN   = 3;
   localparam int AddrW   = 4;
   localparam int DataW   = 32;

   // Result kinds
   localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [KindW-1:0] KIND_ESC_ERR = 2'd1;
   localparam logic [KindW-1:0] KIND_OVERRUN = 2'd2;

   // Register indexes (word address)
   localparam logic [AddrW-3:0] REG_FLAG    = 2'd0;
   localparam logic [AddrW-3:0] REG_ESCAPE  = 2'd1;
   localparam logic [AddrW-3:0] REG_MASK    = 2'd2;
   localparam logic [AddrW-3:0] REG_MAX_LEN = 2'd3;

   // Reset values
   localparam logic [ByteW-1:0] RST_FLAG    = 8'd126;
   localparam logic [ByteW-1:0] RST_ESCAPE  = 8'd125;
   localparam logic [ByteW-1:0] RST_MASK    = 8'd32;
   localparam logic [LenW-1:0]  RST_MAX_LEN = 16'd4096;

   typedef struct packed {
      logic [ByteW-1:0] flag_value;
      logic [ByteW-1:0] escape_value;
      logic [ByteW-1:0] unescape_mask;
      logic [LenW-1:0]  max_frame_len;
   } cfg_type;

   typedef struct packed {
      logic [KindW-1:0] out_kind;
      logic [ByteW-1:0] payload_byte;
      logic             last_of_frame;
   } result_type;

endpackage

// ===== hdl/phdlc_if.sv =====
// ---------------------------------------------------------------------------
// PPP async HDLC deframer channels
// Valid/ready channels for received bytes and for deframed results.
// ---------------------------------------------------------------------------
interface phdlc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface phdlc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] out_kind;
   logic [7:0] payload_byte;
   logic       last_of_frame;

   modport source (output valid, output out_kind, output payload_byte,
                   output last_of_frame, input ready);
   modport sink (input valid, input out_kind, input payload_byte,
                 input last_of_frame, output ready);
endinterface

// ===== hdl/phdlc_csr.sv =====
// ---------------------------------------------------------------------------
// PPP async HDLC deframer registers
// APB-style register file holding flag, escape, mask and frame limit.
// ---------------------------------------------------------------------------
module phdlc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [phdlc_pkg::AddrW-1:0]     paddr,
   input  logic [phdlc_pkg::DataW-1:0]     pwdata,
   output logic [phdlc_pkg::DataW-1:0]     prdata,
   output logic                            pready,
   output phdlc_pkg::cfg_type              cfg
);

   phdlc_pkg::cfg_type cfg_ff, cfg_in;
   logic               wr_en;
   logic [phdlc_pkg::AddrW-3:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[phdlc_pkg::AddrW-1:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            phdlc_pkg::REG_FLAG:    cfg_in.flag_value    = pwdata[phdlc_pkg::ByteW-1:0];
            phdlc_pkg::REG_ESCAPE:  cfg_in.escape_value  = pwdata[phdlc_pkg::ByteW-1:0];
            phdlc_pkg::REG_MASK:    cfg_in.unescape_mask = pwdata[phdlc_pkg::ByteW-1:0];
            phdlc_pkg::REG_MAX_LEN: cfg_in.max_frame_len = pwdata[phdlc_pkg::LenW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         phdlc_pkg::REG_FLAG:    prdata = {24'd0, cfg_ff.flag_value};
         phdlc_pkg::REG_ESCAPE:  prdata = {24'd0, cfg_ff.escape_value};
         phdlc_pkg::REG_MASK:    prdata = {24'd0, cfg_ff.unescape_mask};
         phdlc_pkg::REG_MAX_LEN: prdata = {16'd0, cfg_ff.max_frame_len};
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_value    <= phdlc_pkg::RST_FLAG;
         cfg_ff.escape_value  <= phdlc_pkg::RST_ESCAPE;
         cfg_ff.unescape_mask <= phdlc_pkg::RST_MASK;
         cfg_ff.max_frame_len <= phdlc_pkg::RST_MAX_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/phdlc_core.sv =====
// ---------------------------------------------------------------------------
// PPP async HDLC deframer datapath
// Input register, unstuffing and FCS hold-back logic, result register.
// ---------------------------------------------------------------------------
module phdlc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  phdlc_pkg::cfg_type            cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [phdlc_pkg::ByteW-1:0]   in_byte,
   output logic                          out_valid,
   input  logic                          out_ready,
   output phdlc_pkg::result_type         out_data
);

   logic                          s1_valid_ff, s1_valid_in;
   logic [phdlc_pkg::ByteW-1:0]   s1_byte_ff;
   logic                          s1_go;

   logic                          esc_ff, esc_in;
   logic [phdlc_pkg::ByteW-1:0]   held_ff [phdlc_pkg::HeldN];
   logic [phdlc_pkg::ByteW-1:0]   held_in [phdlc_pkg::HeldN];
   logic [phdlc_pkg::CntW-1:0]    cnt_ff, cnt_in;
   logic [phdlc_pkg::LenW-1:0]    len_ff, len_in;

   logic                          out_valid_ff, out_valid_in;
   phdlc_pkg::result_type         out_ff, out_in;

   logic                          emit;
   phdlc_pkg::result_type         res;
   logic [phdlc_pkg::ByteW-1:0]   data;

   // Stage 1 moves on whenever the result register is free or draining.
   assign s1_go     = s1_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready  = !s1_valid_ff || s1_go;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign data      = esc_ff ? (s1_byte_ff ^ cfg.unescape_mask) : s1_byte_ff;

   always_comb begin
      esc_in  = esc_ff;
      held_in = held_ff;
      cnt_in  = cnt_ff;
      len_in  = len_ff;
      emit    = 1'b0;
      res.out_kind      = phdlc_pkg::KIND_PAYLOAD;
      res.payload_byte  = '0;
      res.last_of_frame = 1'b0;

      if (s1_go) begin
         if (s1_byte_ff == cfg.flag_value) begin
            esc_in = 1'b0;
            cnt_in = '0;
            len_in = '0;
            if (esc_ff) begin
               emit         = 1'b1;
               res.out_kind = phdlc_pkg::KIND_ESC_ERR;
            end else if (cnt_ff == 2'd1 || cnt_ff == 2'd3) begin
               // Release the oldest held byte as the frame's last: the byte ahead of the two FCS bytes, or a lone byte.
               emit              = 1'b1;
               res.payload_byte  = held_ff[0];
               res.last_of_frame = 1'b1;
            end
         end else if (s1_byte_ff == cfg.escape_value) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            if (len_ff >= cfg.max_frame_len) begin
               cnt_in       = '0;
               len_in       = '0;
               emit         = 1'b1;
               res.out_kind = phdlc_pkg::KIND_OVERRUN;
            end else begin
               len_in = len_ff + 16'd1;
               case (cnt_ff)
                  2'd0: begin
                     held_in[0] = data;
                     cnt_in     = 2'd1;
                  end
                  2'd1: begin
                     held_in[1] = data;
                     cnt_in     = 2'd2;
                  end
                  2'd2: begin
                     held_in[2] = data;
                     cnt_in     = 2'd3;
                  end
                  default: begin
                     // Push out the oldest held byte.
                     emit             = 1'b1;
                     res.payload_byte = held_ff[0];
                     held_in[0]       = held_ff[1];
                     held_in[1]       = held_ff[2];
                     held_in[2]       = data;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      s1_valid_in  = (s1_valid_ff && !s1_go) || in_valid;
      out_valid_in = out_valid_ff && !out_ready;
      out_in       = out_ff;
      if (s1_go && emit) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         esc_ff       <= 1'b0;
         cnt_ff       <= '0;
         len_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         esc_ff       <= esc_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_byte_ff <= in_byte;
      end
      held_ff <= held_in;
      out_ff  <= out_in;
   end

endmodule

// ===== hdl/ppp_async_hdlc_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// PPP async HDLC deframer
// Byte unstuffing and FCS removal for a PPP async HDLC receive stream.
// ---------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  req       in    valid / ready    rx_byte
//  rsp       out   valid / ready    out_kind, payload_byte, last_of_frame
//  csr       in    APB write/read   flag, escape, mask, max frame length
//
//  One byte per cycle sustained while the result side is ready.
//  Latency is set by the input register and the result register.
//  Synchronous reset clears frame state; registers return to defaults.
//  A stalled result holds; one more byte waits in the input register.
// ---------------------------------------------------------------------------
module ppp_async_hdlc_deframer_unit (
   input  logic                          clock,
   input  logic                          reset,
   phdlc_req_if.sink                     req,
   phdlc_rsp_if.source                   rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [phdlc_pkg::AddrW-1:0]   paddr,
   input  logic [phdlc_pkg::DataW-1:0]   pwdata,
   output logic [phdlc_pkg::DataW-1:0]   prdata,
   output logic                          pready
);

   phdlc_pkg::cfg_type    cfg;
   phdlc_pkg::result_type result;

   phdlc_csr u_phdlc_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   phdlc_core u_phdlc_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_byte   (req.rx_byte),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (result)
   );

   assign rsp.out_kind      = result.out_kind;
   assign rsp.payload_byte  = result.payload_byte;
   assign rsp.last_of_frame = result.last_of_frame;

endmodule

// ===== hdl/phdlc_checker.sv =====
// ---------------------------------------------------------------------------
// PPP async HDLC deframer checker
// Port-level assertions, bound to the deframer top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module phdlc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_out_kind,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_last_of_frame
);

   logic rsp_beat;
   logic req_beat;

   assign rsp_beat = rsp_valid && rsp_ready;
   assign req_beat = req_valid && req_ready;

   // A stalled result beat holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_kind) && $stable(rsp_payload_byte) && $stable(rsp_last_of_frame), "result beat changed while stalled")

   // Error results carry no byte and no end mark.
   `ASSERT_IMPLY(a_err_clean, clock, reset, rsp_valid && rsp_out_kind != phdlc_pkg::KIND_PAYLOAD, rsp_payload_byte == 8'd0 && !rsp_last_of_frame, "error result carries payload")

   // Only the three defined kinds appear.
   `ASSERT_IMPLY(a_kind_range, clock, reset, rsp_valid, rsp_out_kind == phdlc_pkg::KIND_PAYLOAD || rsp_out_kind == phdlc_pkg::KIND_ESC_ERR || rsp_out_kind == phdlc_pkg::KIND_OVERRUN, "undefined result kind")

   // A result starts only after a byte beat on the request channel.
   `ASSERT_IMPLY(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_beat, 2), "result without a byte")

   // Input is taken whenever the result side drains.
   `ASSERT_IMPLY(a_req_flow, clock, reset, !rsp_valid || rsp_beat, req_ready, "input stalled with result path free")

endmodule

bind ppp_async_hdlc_deframer_unit phdlc_checker u_phdlc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_out_kind      (rsp.out_kind),
   .rsp_payload_byte  (rsp.payload_byte),
   .rsp_last_of_frame (rsp.last_of_frame)
);

// ===== verif/tb_ppp_async_hdlc_deframer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the PPP async HDLC deframer
// A short table of directed bytes and register writes opens the run. Random
// frames then follow under several register settings, stuffed to match the
// current flag, escape and mask, mixed with noise and broken escapes. Each
// result beat is checked against a typed row or a shadow deframer that tracks the registers.
// ---------------------------------------------------------------------------
module tb_ppp_async_hdlc_deframer_unit;

   localparam int ClkHalf     = 10;
   localparam int ResetCycles = 12;
   localparam int SettleCycles = 8;
   localparam int StallLimit  = 4000;
   localparam int PhaseBytes  = 128;
   localparam int NumPhases   = 7;

   typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [1:0]             reg_idx;   // register index, cfg rows only
      logic [15:0]            value;     // register value, or rx byte in [7:0]
      logic                   fixed;     // expectation typed in below
      logic                   n_res;     // typed rows: a result is due
      phdlc_pkg::result_type  res;
   } dir_row_type;

   localparam phdlc_pkg::result_type NO_RES  = '{phdlc_pkg::KIND_PAYLOAD, 8'h00, 1'b0};
   localparam phdlc_pkg::result_type ESC_RES = '{phdlc_pkg::KIND_ESC_ERR, 8'h00, 1'b0};
   localparam phdlc_pkg::result_type OVR_RES = '{phdlc_pkg::KIND_OVERRUN, 8'h00, 1'b0};
   localparam phdlc_pkg::result_type ONE_RES = '{phdlc_pkg::KIND_PAYLOAD, 8'h11, 1'b1};
   localparam phdlc_pkg::result_type LIM_RES = '{phdlc_pkg::KIND_PAYLOAD, 8'h03, 1'b1};
   localparam int DirRows = 27;

   //                kind      reg                     value     fixed n_res result
   localparam dir_row_type DIR_TAB [DirRows] = '{
      // flag with nothing held, then a one-byte frame
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007E, 1'b1, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0011, 1'b1, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007E, 1'b1, 1'b1, ONE_RES},
      // two-byte frame is all FCS: dropped silently
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0022, 1'b1, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0033, 1'b1, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007E, 1'b1, 1'b0, NO_RES},
      // byte extremes, an escaped data byte, a longer frame
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0000, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h00FF, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007D, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h005E, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0044, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007E, 1'b0, 1'b0, NO_RES},
      // flag right after an escape
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0055, 1'b1, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007D, 1'b1, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007E, 1'b1, 1'b1, ESC_RES},
      // escape twice in a row
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007D, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007D, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h005D, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007E, 1'b0, 1'b0, NO_RES},
      // shortest frame limit: second data byte overruns
      '{ROW_CFG,  phdlc_pkg::REG_MAX_LEN, 16'h0001, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0001, 1'b1, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0002, 1'b1, 1'b1, OVR_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0003, 1'b1, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007E, 1'b1, 1'b1, LIM_RES},
      // escape equal to flag: the byte acts as a flag
      '{ROW_CFG,  phdlc_pkg::REG_ESCAPE,  16'h007E, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h0009, 1'b0, 1'b0, NO_RES},
      '{ROW_BYTE, phdlc_pkg::REG_FLAG,    16'h007E, 1'b0, 1'b0, NO_RES}
   };

   logic                        clock;
   logic                        reset;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [phdlc_pkg::AddrW-1:0] paddr;
   logic [phdlc_pkg::DataW-1:0] pwdata;
   logic [phdlc_pkg::DataW-1:0] prdata;
   logic                        pready;

   phdlc_req_if req_ch ();
   phdlc_rsp_if rsp_ch ();

   ppp_async_hdlc_deframer_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the registers and of the frame state
   phdlc_pkg::cfg_type cfg_shadow = '{phdlc_pkg::RST_FLAG, phdlc_pkg::RST_ESCAPE,
                                      phdlc_pkg::RST_MASK, phdlc_pkg::RST_MAX_LEN};
   logic       esc_armed = 1'b0;
   logic [7:0] hold_q [phdlc_pkg::HeldN];
   int         hold_n = 0;
   logic [15:0] frame_bytes = '0;

   phdlc_pkg::result_type deframed_q [$];

   // tag of the beat on the request channel
   logic                  row_fixed = 1'b0;
   logic                  row_n = 1'b0;
   phdlc_pkg::result_type row_res = NO_RES;

   int errors = 0;
   int n_bytes = 0;
   int n_payload = 0;
   int n_frames = 0;
   int n_esc = 0;
   int n_ovr = 0;
   int quiet_cycles = 0;
   int burst_left = 0;
   int stim_bytes = 0;
   bit idle_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #ClkHalf clock = ~clock;
   end

   function automatic void clear_frame_state();
      esc_armed   = 1'b0;
      hold_n      = 0;
      frame_bytes = '0;
   endfunction

   task automatic deframe_predict(input logic [7:0] rx, output bit emits,
                                  output phdlc_pkg::result_type res);
      logic [7:0] b;
      logic [7:0] oldest;
      int         cnt;
      b      = rx;
      emits  = 1'b0;
      res    = NO_RES;
      if (b == cfg_shadow.flag_value) begin
         cnt    = hold_n;
         oldest = hold_q[0];
         if (esc_armed) begin
            res.out_kind = phdlc_pkg::KIND_ESC_ERR;
            emits        = 1'b1;
         end else if (cnt == 1 || cnt == 3) begin
            res.payload_byte  = oldest;
            res.last_of_frame = 1'b1;
            emits             = 1'b1;
         end
         clear_frame_state();
      end else if (b == cfg_shadow.escape_value) begin
         esc_armed = 1'b1;
      end else begin
         if (esc_armed) b = b ^ cfg_shadow.unescape_mask;
         esc_armed = 1'b0;
         if (frame_bytes >= cfg_shadow.max_frame_len) begin
            clear_frame_state();
            res.out_kind = phdlc_pkg::KIND_OVERRUN;
            emits        = 1'b1;
         end else begin
            frame_bytes = frame_bytes + 16'd1;
            if (hold_n < phdlc_pkg::HeldN) begin
               hold_q[hold_n] = b;
               hold_n++;
            end else begin
               // shift out the oldest held byte
               res.payload_byte = hold_q[0];
               emits            = 1'b1;
               hold_q[0]        = hold_q[1];
               hold_q[1]        = hold_q[2];
               hold_q[2]        = b;
            end
         end
      end
   endtask

   // predict on request beats, check on result beats, track register writes
   always @(posedge clock) begin : monitor
      bit                    emits;
      phdlc_pkg::result_type pred;
      phdlc_pkg::result_type got;
      phdlc_pkg::result_type want;
      if (!reset) begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[phdlc_pkg::AddrW-1:2])
               phdlc_pkg::REG_FLAG:    cfg_shadow.flag_value    = pwdata[7:0];
               phdlc_pkg::REG_ESCAPE:  cfg_shadow.escape_value  = pwdata[7:0];
               phdlc_pkg::REG_MASK:    cfg_shadow.unescape_mask = pwdata[7:0];
               phdlc_pkg::REG_MAX_LEN: cfg_shadow.max_frame_len = pwdata[15:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            deframe_predict(req_ch.rx_byte, emits, pred);
            n_bytes++;
            if (row_fixed) begin
               if (row_n) deframed_q.push_back(row_res);
            end else if (emits) begin
               deframed_q.push_back(pred);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_kind, rsp_ch.payload_byte, rsp_ch.last_of_frame};
            case (got.out_kind)
               phdlc_pkg::KIND_ESC_ERR: n_esc++;
               phdlc_pkg::KIND_OVERRUN: n_ovr++;
               default: begin
                  n_payload++;
                  if (got.last_of_frame) n_frames++;
               end
            endcase
            if (deframed_q.size() == 0) begin
               $display("%0t: unexpected result kind %0d byte %02h last %0d",
                        $time, got.out_kind, got.payload_byte, got.last_of_frame);
               errors++;
            end else begin
               want = deframed_q.pop_front();
               if (got !== want) begin
                  $display("%0t: result mismatch: expected kind %0d byte %02h last %0d, %s",
                           $time, want.out_kind, want.payload_byte, want.last_of_frame,
                           $sformatf("actual kind %0d byte %02h last %0d",
                                     got.out_kind, got.payload_byte, got.last_of_frame));
                  errors++;
               end
            end
         end
      end
   end

   // watchdog: any handshake counts as progress
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (psel && penable && pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, deframed_q.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   // result-side backpressure on rotating patterns
   logic [15:0] stall_pat = 16'hFFFF;
   int          stall_age = 0;
   always @(posedge clock) begin
      if (stall_age == 0) begin
         case ($urandom_range(0, 4))
            0:       stall_pat = 16'hFFFF;
            1:       stall_pat = 16'($urandom);
            2:       stall_pat = 16'h00FF;
            default: stall_pat = 16'($urandom) | 16'($urandom);
         endcase
         stall_age = 48;
      end
      stall_age--;
      rsp_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[15:1]};
   end

   task automatic send_byte(input logic [7:0] b, input logic fixed, input logic n_res,
                            input phdlc_pkg::result_type r);
      if (idle_on && burst_left <= 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      row_fixed      <= fixed;
      row_n          <= n_res;
      row_res        <= r;
      stim_bytes++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold the sender until every expected result is out, then settle
   task automatic drain_results(input int settle);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_write_check(input logic [1:0] idx, input logic [15:0] value);
      logic [31:0] want;
      logic [31:0] keep;
      keep = (idx == phdlc_pkg::REG_MAX_LEN) ? 32'h0000_FFFF : 32'h0000_00FF;
      want = {16'h0, value} & keep;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= want;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // read back
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & keep) !== want) begin
         $display("%0t: register %0d readback: expected %08h actual %08h",
                  $time, idx, want, prdata & keep);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // one frame stuffed for the current settings, or noise, or a broken escape
   task automatic send_random_frame();
      logic [7:0] seq [$];
      logic [7:0] d;
      int         len;
      int         lim;
      int         pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom));
      end else begin
         lim = (cfg_shadow.max_frame_len <= 20) ? cfg_shadow.max_frame_len + 3 : 12;
         len = (pick < 4) ? $urandom_range(0, lim) : $urandom_range(0, 10);
         if (pick == 3) seq.push_back(cfg_shadow.flag_value);
         for (int i = 0; i < len; i++) begin
            d = 8'($urandom);
            if ($urandom_range(0, 7) == 0)
               d = $urandom_range(0, 1) ? cfg_shadow.flag_value : cfg_shadow.escape_value;
            if (d == cfg_shadow.flag_value || d == cfg_shadow.escape_value
                || $urandom_range(0, 15) == 0) begin
               seq.push_back(cfg_shadow.escape_value);
               seq.push_back(d ^ cfg_shadow.unescape_mask);
            end else begin
               seq.push_back(d);
            end
         end
         if (pick == 2) seq.push_back(cfg_shadow.escape_value);
         seq.push_back(cfg_shadow.flag_value);
      end
      foreach (seq[i]) send_byte(seq[i], 1'b0, 1'b0, NO_RES);
   endtask

   initial begin : stimulus
      logic [7:0]  f_val;
      logic [7:0]  e_val;
      logic [7:0]  m_val;
      logic [15:0] l_val;
      int          quota;
      reset          <= 1'b1;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      req_ch.valid   <= 1'b0;
      req_ch.rx_byte <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_TAB[i]) begin
         if (DIR_TAB[i].kind == ROW_CFG) begin
            drain_results(SettleCycles);
            csr_write_check(DIR_TAB[i].reg_idx, DIR_TAB[i].value);
         end else begin
            send_byte(DIR_TAB[i].value[7:0], DIR_TAB[i].fixed, DIR_TAB[i].n_res,
                      DIR_TAB[i].res);
         end
      end

      for (int p = 0; p < NumPhases; p++) begin
         drain_results(SettleCycles);
         f_val = 8'($urandom);
         e_val = ($urandom_range(0, 3) == 0) ? f_val : 8'($urandom);
         m_val = 8'($urandom);
         case (p)
            0:       l_val = 16'($urandom_range(1, 65535));
            1: begin
               f_val = 8'h00; e_val = 8'hFF; m_val = 8'hFF; l_val = 16'd1;
            end
            2: begin
               f_val = 8'hFF; e_val = 8'h00; m_val = 8'h00; l_val = 16'hFFFF;
            end
            3:       l_val = 16'($urandom_range(2, 12));
            4: begin
               f_val = phdlc_pkg::RST_FLAG;
               e_val = phdlc_pkg::RST_ESCAPE;
               m_val = phdlc_pkg::RST_MASK;
               l_val = phdlc_pkg::RST_MAX_LEN;
            end
            5:       l_val = 16'($urandom_range(1, 20));
            default: l_val = 16'd3;
         endcase
         csr_write_check(phdlc_pkg::REG_FLAG, {8'h0, f_val});
         csr_write_check(phdlc_pkg::REG_ESCAPE, {8'h0, e_val});
         csr_write_check(phdlc_pkg::REG_MASK, {8'h0, m_val});
         csr_write_check(phdlc_pkg::REG_MAX_LEN, l_val);
         // one stretch with the sender never idling
         idle_on = (p != 4);
         quota = stim_bytes + PhaseBytes;
         while (stim_bytes < quota) begin
            if (p == 3 && stim_bytes >= quota - PhaseBytes / 2
                && stim_bytes < quota - PhaseBytes / 2 + 8)
               drain_results(0);
            send_random_frame();
         end
      end

      drain_results(SettleCycles);
      if (deframed_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, deframed_q.size());
         errors++;
      end
      $display("Covered %0d bytes over %0d register settings: %0d payload bytes, %0d frames",
               n_bytes, NumPhases + 3, n_payload, n_frames);
      $display("Errors reported by the block: %0d escaped flag, %0d overrun; %0d mismatches",
               n_esc, n_ovr, errors);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
